FILE: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer.
// Used by text_console_writer and tcw_checker; no dependencies.

package tcw_pkg;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int RC_W  = COL_W + ROW_W;
  localparam int OFS_W = 11;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0f;

  typedef enum logic [1:0] {
    KIND_PUT,
    KIND_BACKSPACE,
    KIND_SETPOS,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_REJECT,
    STAT_DROP
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ADDR,
    ST_ACCESS,
    ST_SCRL_ADDR,
    ST_SCRL_CLEAR,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/text_console_writer.sv
// text_console_writer: text-mode screen engine with cell memory and cursor.
// Depends on tcw_pkg. Single module; cell store is an internal single-port memory.
//
// Each accepted item is worked on alone while in_stall is high. Set position,
// a newline, a dropped put, a rejected read and a backspace at the origin go
// from the execute state straight to the finish state; a put, a backspace or a
// read cell first go through the shared row*COLUMNS+col address unit and then
// one access of the single-port cell memory. A put or newline that scrolls also
// passes through the scroll address and scroll clear states: rows live in a
// ring, so a scroll only moves the top-row pointer and clears one row, one cell a
// cycle. The cursor offset of every result comes from the same address unit.
// After reset the cell memory is cleared before the first item is taken;
// configuration writes are taken at any time. A finished result sits in an
// output register, so the next item may be accepted while it waits.

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [6:0]  col,
  input  logic [4:0]  row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_offset,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled,
  output logic [1:0]  status
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0]         ADDR_LAST = ADDR_W'(CELLS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] COL_LAST  = tcw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST  = tcw_pkg::ROW_W'(ROWS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_END   = tcw_pkg::ROW_W'(ROWS);
  localparam logic [tcw_pkg::ROW_W:0]   ROWS_X    = (tcw_pkg::ROW_W + 1)'(ROWS);

  // configuration
  logic [7:0] text_attribute;
  logic       autoscroll_enable;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute    <= tcw_pkg::ATTR_RESET;
      autoscroll_enable <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        autoscroll_enable <= pwdata[0];
      end else begin
        text_attribute <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {31'd0, autoscroll_enable};
    end else begin
      prdata = {24'd0, text_attribute};
    end
  end

  // control and datapath registers
  tcw_pkg::state_t  state, state_next;
  logic [tcw_pkg::COL_W-1:0] cur_col;
  logic [tcw_pkg::ROW_W-1:0] cur_row;
  logic [tcw_pkg::ROW_W-1:0] top;
  logic [ADDR_W-1:0]         addr;
  logic [tcw_pkg::COL_W-1:0] clr_cnt;

  tcw_pkg::kind_t   op_kind;
  logic [7:0]       op_char;
  logic [6:0]       op_col;
  logic [4:0]       op_row;
  logic             op_wr, op_rd, op_scroll;
  tcw_pkg::status_t op_status;
  logic [tcw_pkg::COL_W-1:0] wr_col;
  logic [tcw_pkg::ROW_W-1:0] wr_row;
  logic [7:0]       wr_char;
  logic [15:0]      rd_data;

  logic [15:0] cells [CELLS];
  logic        mem_we;
  logic [15:0] mem_wdata;

  // item decode
  logic [tcw_pkg::COL_W-1:0] x_col, x_wcol;
  logic [tcw_pkg::ROW_W-1:0] x_row, x_wrow;
  logic [7:0]       x_wchar;
  logic             x_wr, x_rd, x_scroll;
  tcw_pkg::status_t x_status;

  always_comb begin
    x_col    = cur_col;
    x_row    = cur_row;
    x_wcol   = cur_col;
    x_wrow   = cur_row;
    x_wchar  = op_char;
    x_wr     = 1'b0;
    x_rd     = 1'b0;
    x_scroll = 1'b0;
    x_status = tcw_pkg::STAT_OK;
    unique case (op_kind)
      tcw_pkg::KIND_PUT: begin
        if (cur_row > ROW_LAST || cur_col > COL_LAST) begin
          x_status = tcw_pkg::STAT_DROP;
        end else begin
          x_wr = (op_char != tcw_pkg::NEWLINE_CODE);
          if (op_char == tcw_pkg::NEWLINE_CODE || cur_col == COL_LAST) begin
            x_col = '0;
            if (cur_row == ROW_LAST) begin
              if (autoscroll_enable) begin
                x_scroll = 1'b1;
              end else begin
                x_row = ROW_END;
              end
            end else begin
              x_row = cur_row + 1'b1;
            end
          end else begin
            x_col = cur_col + 1'b1;
          end
        end
      end
      tcw_pkg::KIND_BACKSPACE: begin
        if (!(cur_col == '0 && cur_row == '0)) begin
          if (cur_col == '0) begin
            x_row = cur_row - 1'b1;
            x_col = COL_LAST;
          end else begin
            x_col = cur_col - 1'b1;
          end
          x_wcol  = x_col;
          x_wrow  = x_row;
          x_wchar = tcw_pkg::SPACE_CODE;
          x_wr    = (x_row <= ROW_LAST);
        end
      end
      tcw_pkg::KIND_SETPOS: begin
        if (op_col <= COL_LAST && op_row <= ROW_LAST) begin
          x_col = op_col;
          x_row = op_row;
        end else begin
          x_status = tcw_pkg::STAT_REJECT;
        end
      end
      tcw_pkg::KIND_READ: begin
        if (op_col <= COL_LAST && op_row <= ROW_LAST) begin
          x_wcol = op_col;
          x_wrow = op_row;
          x_rd   = 1'b1;
        end else begin
          x_status = tcw_pkg::STAT_REJECT;
        end
      end
    endcase
  end

  // shared address unit: optional physical row mapping, then row*COLUMNS + col
  logic [tcw_pkg::ROW_W-1:0] map_row, phys_row;
  logic [tcw_pkg::ROW_W:0]   map_sum;
  logic                      unit_map;
  logic [tcw_pkg::ROW_W-1:0] unit_row;
  logic [tcw_pkg::COL_W-1:0] unit_col;
  logic [tcw_pkg::RC_W-1:0]  unit_sum;

  assign map_sum  = {1'b0, map_row} + {1'b0, top};
  assign phys_row = (map_sum >= ROWS_X) ? tcw_pkg::ROW_W'(map_sum - ROWS_X)
                                        : map_sum[tcw_pkg::ROW_W-1:0];
  assign unit_sum = tcw_pkg::RC_W'(unit_map ? phys_row : unit_row)
                  * tcw_pkg::RC_W'(COLUMNS) + tcw_pkg::RC_W'(unit_col);

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = '0;
    map_row   = wr_row;
    unit_map  = 1'b1;
    unit_row  = cur_row;
    unit_col  = wr_col;
    unique case (state)
      tcw_pkg::ST_CLEAR:      mem_we = 1'b1;
      tcw_pkg::ST_IDLE:       in_stall = 1'b0;
      tcw_pkg::ST_EXEC:       ;
      tcw_pkg::ST_ADDR:       ;
      tcw_pkg::ST_ACCESS: begin
        mem_we    = op_wr;
        mem_wdata = {text_attribute, wr_char};
      end
      tcw_pkg::ST_SCRL_ADDR: begin
        map_row  = '0;
        unit_col = '0;
      end
      tcw_pkg::ST_SCRL_CLEAR: mem_we = 1'b1;
      tcw_pkg::ST_FINISH: begin
        unit_map = 1'b0;
        unit_col = cur_col;
      end
      default:                ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_CLEAR: begin
        if (addr == ADDR_LAST) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        if (x_wr || x_rd)  state_next = tcw_pkg::ST_ADDR;
        else if (x_scroll) state_next = tcw_pkg::ST_SCRL_ADDR;
        else               state_next = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_ADDR:       state_next = tcw_pkg::ST_ACCESS;
      tcw_pkg::ST_ACCESS: begin
        state_next = op_scroll ? tcw_pkg::ST_SCRL_ADDR : tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_SCRL_ADDR:  state_next = tcw_pkg::ST_SCRL_CLEAR;
      tcw_pkg::ST_SCRL_CLEAR: begin
        if (clr_cnt == COL_LAST) state_next = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_CLEAR;
      cur_col <= '0;
      cur_row <= '0;
      top     <= '0;
      addr    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        tcw_pkg::ST_CLEAR: addr <= addr + 1'b1;
        tcw_pkg::ST_IDLE: begin
          op_kind <= tcw_pkg::kind_t'(kind);
          op_char <= char_code;
          op_col  <= col;
          op_row  <= row;
        end
        tcw_pkg::ST_EXEC: begin
          cur_col   <= x_col;
          cur_row   <= x_row;
          wr_col    <= x_wcol;
          wr_row    <= x_wrow;
          wr_char   <= x_wchar;
          op_wr     <= x_wr;
          op_rd     <= x_rd;
          op_scroll <= x_scroll;
          op_status <= x_status;
        end
        tcw_pkg::ST_ADDR: addr <= unit_sum[ADDR_W-1:0];
        tcw_pkg::ST_ACCESS: ;
        tcw_pkg::ST_SCRL_ADDR: begin
          addr    <= unit_sum[ADDR_W-1:0];
          top     <= (top == ROW_LAST) ? '0 : top + 1'b1;
          clr_cnt <= '0;
        end
        tcw_pkg::ST_SCRL_CLEAR: begin
          addr    <= addr + 1'b1;
          clr_cnt <= clr_cnt + 1'b1;
        end
        tcw_pkg::ST_FINISH: ;
        default: ;
      endcase
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (mem_we) cells[addr] <= mem_wdata;
    if (state == tcw_pkg::ST_ACCESS && op_rd) rd_data <= cells[addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcw_pkg::ST_FINISH && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcw_pkg::ST_FINISH && (!out_valid || !out_stall)) begin
      cursor_col    <= cur_col;
      cursor_row    <= cur_row;
      cursor_offset <= unit_sum[tcw_pkg::OFS_W-1:0];
      cell_char     <= op_rd ? rd_data[7:0] : 8'd0;
      cell_attr     <= op_rd ? rd_data[15:8] : 8'd0;
      scrolled      <= op_scroll;
      status        <= op_status;
    end
  end

endmodule

FILE: hw/rtl/tcw_checker.sv
// tcw_port_asserts: port-level assertions for text_console_writer, with its bind.
// Depends on tcw_pkg and the top level's port list.

module tcw_port_asserts #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  cursor_col,
  input logic [4:0]  cursor_row,
  input logic [10:0] cursor_offset,
  input logic        scrolled,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(cursor_offset) && $stable(status))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before item finished");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_offset == 11'(int'(cursor_row) * COLUMNS + int'(cursor_col)))
    else $error("cursor offset does not match cursor position");

  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |->
      cursor_col == '0 && cursor_row == 5'(ROWS - 1) && status == tcw_pkg::STAT_OK)
    else $error("scroll left cursor off the last row start");

endmodule

bind text_console_writer tcw_port_asserts #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tcw_port_asserts (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .cursor_col(cursor_col),
  .cursor_row(cursor_row),
  .cursor_offset(cursor_offset),
  .scrolled(scrolled),
  .status(status)
);

FILE: dv/tcw_checker.sv
// tcw_checker: predicts and checks every item of text_console_writer.
// Follows the register port and both item channels; depends on tcw_pkg.

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int         COLUMNS     = 80,
  parameter int         ROWS        = 25,
  parameter logic [2:0] ATTR_ADDR   = 3'd0,
  parameter logic [2:0] SCROLL_ADDR = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [6:0]  col,
  input  logic [4:0]  row,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  cursor_col,
  input  logic [4:0]  cursor_row,
  input  logic [10:0] cursor_offset,
  input  logic [7:0]  cell_char,
  input  logic [7:0]  cell_attr,
  input  logic        scrolled,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          scrolls_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [OFS_W-1:0] ofs;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic             scr;
    logic [1:0]       st;
  } cursor_report_t;

  cursor_report_t expected_reports[$];
  logic [15:0]    screen [ROWS*COLUMNS];
  int unsigned    cur_col;
  int unsigned    cur_row;
  logic [7:0]     text_attr;
  logic           scroll_on;

  function automatic void put_cell(int unsigned c, int unsigned r, logic [7:0] ch);
    if (c < COLUMNS && r < ROWS) begin
      screen[r*COLUMNS + c] = {text_attr, ch};
    end
  endfunction

  // cursor to column 0 of the next row; returns 1 when the screen scrolled
  function automatic logic line_feed();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      if (!scroll_on) begin
        cur_row = ROWS;
        return 1'b0;
      end
      for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen[i] = screen[i+COLUMNS];
      for (int i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++) screen[i] = '0;
      cur_row = ROWS - 1;
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic cursor_report_t console_step(kind_t k, logic [7:0] ch,
                                                  logic [6:0] c, logic [4:0] r);
    cursor_report_t rep;
    int unsigned    pos;
    rep = '0;
    rep.st = STAT_OK;
    case (k)
      KIND_PUT: begin
        if (cur_row >= ROWS || cur_col >= COLUMNS) begin
          rep.st = STAT_DROP;
        end else if (ch == NEWLINE_CODE) begin
          rep.scr = line_feed();
        end else begin
          put_cell(cur_col, cur_row, ch);
          if (cur_col + 1 >= COLUMNS) begin
            rep.scr = line_feed();
          end else begin
            cur_col++;
          end
        end
      end
      KIND_BACKSPACE: begin
        if (cur_col != 0 || cur_row != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COLUMNS - 1;
          end else begin
            cur_col--;
          end
          put_cell(cur_col, cur_row, SPACE_CODE);
        end
      end
      KIND_SETPOS: begin
        if (c < COLUMNS && r < ROWS) begin
          cur_col = c;
          cur_row = r;
        end else begin
          rep.st = STAT_REJECT;
        end
      end
      default: begin
        if (c < COLUMNS && r < ROWS) begin
          {rep.attr, rep.ch} = screen[r*COLUMNS + c];
        end else begin
          rep.st = STAT_REJECT;
        end
      end
    endcase
    pos = cur_row * COLUMNS + cur_col;
    rep.col = cur_col[COL_W-1:0];
    rep.row = cur_row[ROW_W-1:0];
    rep.ofs = pos[OFS_W-1:0];
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_reports.delete();
      foreach (screen[i]) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      text_attr = ATTR_RESET;
      scroll_on = 1'b1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ATTR_ADDR) text_attr = pwdata[7:0];
        else if (paddr == SCROLL_ADDR) scroll_on = pwdata[0];
      end
      // retire before predicting: a result never belongs to an item taken this edge
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no item outstanding: cursor_col %0d, cursor_row %0d",
                 cursor_col, cursor_row);
          fail_count++;
        end else begin
          cursor_report_t want;
          want = expected_reports.pop_front();
          check_field("cursor_col", want.col, cursor_col);
          check_field("cursor_row", want.row, cursor_row);
          check_field("cursor_offset", want.ofs, cursor_offset);
          check_field("cell_char", want.ch, cell_char);
          check_field("cell_attr", want.attr, cell_attr);
          check_field("scrolled", want.scr, scrolled);
          check_field("status", want.st, status);
          results_checked++;
          if (want.scr) scrolls_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(console_step(kind_t'(kind), char_code, col, row));
      end
    end
    pending = expected_reports.size();
  end

endmodule

FILE: dv/text_console_writer_tb.sv
// text_console_writer_tb: drives register writes and items into text_console_writer.
// Stimulus and verdict only; checking lives in tcw_checker. Depends on tcw_pkg.

module text_console_writer_tb
  import tcw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         COLUMNS     = 80;
  localparam int         ROWS        = 25;
  localparam logic [2:0] ATTR_ADDR   = 3'd0;
  localparam logic [2:0] SCROLL_ADDR = 3'd4;
  localparam int         PHASE_ITEMS = 330;
  localparam int         HOLD_CYCLES = 400;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  kind      = '0;
  logic [7:0]  char_code = '0;
  logic [6:0]  col       = '0;
  logic [4:0]  row       = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_offset;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        scrolled;
  logic [1:0]  status;

  int fail_count;
  int pending;
  int results_checked;
  int scrolls_seen;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go       = 1'b0;
  int hold_left     = 0;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (.*);

  tcw_checker #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .ATTR_ADDR(ATTR_ADDR), .SCROLL_ADDR(SCROLL_ADDR)
  ) checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // entered and left at a falling edge; valid stays up until the next call or a drain
  task automatic send_item(kind_t k, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    col       <= c;
    row       <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // mostly on screen with a lean to the bottom rows; some anywhere in the field range
  function automatic void pick_position(output logic [6:0] c, output logic [4:0] r);
    if ($urandom_range(9) == 0) begin
      c = 7'($urandom_range(127));
      r = 5'($urandom_range(31));
    end else begin
      c = 7'($urandom_range(COLUMNS-1));
      r = $urandom_range(1) ? 5'($urandom_range(ROWS-1, ROWS-2))
                            : 5'($urandom_range(ROWS-1));
    end
  endfunction

  task automatic send_random_op();
    int         roll;
    logic [7:0] ch;
    logic [6:0] c;
    logic [4:0] r;
    roll = $urandom_range(99);
    ch = 8'($urandom_range(255));
    c = 7'($urandom_range(127));
    r = 5'($urandom_range(31));
    if (roll < 58) begin
      if ($urandom_range(9) == 0) ch = NEWLINE_CODE;
      send_item(KIND_PUT, ch, c, r);
    end else if (roll < 68) begin
      send_item(KIND_BACKSPACE, ch, c, r);
    end else if (roll < 84) begin
      pick_position(c, r);
      send_item(KIND_SETPOS, ch, c, r);
    end else begin
      pick_position(c, r);
      send_item(KIND_READ, ch, c, r);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    reg_write(ATTR_ADDR, 32'hff);
    reg_write(SCROLL_ADDR, 32'h1);
    send_item(KIND_READ, 8'h00, 7'd0, 5'd0);
    send_item(KIND_PUT, 8'h41, 7'd0, 5'd0);
    send_item(KIND_PUT, 8'h00, 7'd127, 5'd31);
    send_item(KIND_PUT, 8'hff, 7'd0, 5'd0);
    send_item(KIND_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_item(KIND_SETPOS, 8'h00, 7'(COLUMNS-1), 5'(ROWS-1));
    send_item(KIND_PUT, 8'h5a, 7'd0, 5'd0);            // wrap off the last row
    send_item(KIND_READ, 8'h00, 7'(COLUMNS-1), 5'(ROWS-2));
    send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 5'd0);     // newline on the last row
    send_item(KIND_SETPOS, 8'h00, 7'd127, 5'd31);
    send_item(KIND_SETPOS, 8'h00, 7'(COLUMNS), 5'd0);
    send_item(KIND_READ, 8'h00, 7'd0, 5'(ROWS));
    send_item(KIND_SETPOS, 8'h00, 7'd0, 5'd0);
    send_item(KIND_BACKSPACE, 8'h00, 7'd0, 5'd0);      // origin: no effect
    send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    drain();

    reg_write(SCROLL_ADDR, 32'h0);
    reg_write(ATTR_ADDR, 32'h0);
    send_item(KIND_SETPOS, 8'h00, 7'(COLUMNS-1), 5'(ROWS-1));
    send_item(KIND_PUT, 8'h7e, 7'd0, 5'd0);            // parks past the bottom
    send_item(KIND_PUT, 8'h55, 7'd0, 5'd0);
    send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    send_item(KIND_BACKSPACE, 8'h00, 7'd0, 5'd0);      // back onto the last row
    send_item(KIND_SETPOS, 8'h00, 7'd0, 5'(ROWS-1));
    send_item(KIND_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    drain();
    reg_write(SCROLL_ADDR, 32'h1);
    send_item(KIND_PUT, 8'h31, 7'd0, 5'd0);            // still dropped
    send_item(KIND_SETPOS, 8'h00, 7'd0, 5'd5);
    send_item(KIND_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_item(KIND_READ, 8'h00, 7'(COLUMNS-1), 5'd4);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 69;
          reg_write(ATTR_ADDR, $urandom_range(255));
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 34;
          reg_write(SCROLL_ADDR, 32'h0);
          reg_write(ATTR_ADDR, 32'h0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          reg_write(SCROLL_ADDR, 32'h1);
          reg_write(ATTR_ADDR, 32'hff);
          hold_go = 1'b1;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_op();
      drain();
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d items over three idle profiles, autoscroll on and off.", items_sent);
    $display("Checked %0d results, %0d of them with a scroll.", results_checked,
             scrolls_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
